### src/assert_macros.svh
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked at every edge outside reset
`define SISE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define SISE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/sise_pkg.sv
// shared types and codes for the sorted interval set engine
// no dependencies
package sise_pkg;

  localparam int MaxRangesDefault = 64;

  localparam logic [3:0] K_ADD       = 4'd0;
  localparam logic [3:0] K_REMOVE    = 4'd1;
  localparam logic [3:0] K_INSERT    = 4'd2;
  localparam logic [3:0] K_DELETE    = 4'd3;
  localparam logic [3:0] K_FIND      = 4'd4;
  localparam logic [3:0] K_NEAREST   = 4'd5;
  localparam logic [3:0] K_CONTAINS  = 4'd6;
  localparam logic [3:0] K_TRUNC_LO  = 4'd7;
  localparam logic [3:0] K_TRUNC_HI  = 4'd8;
  localparam logic [3:0] K_CLEAR     = 4'd9;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  // wide signed working value for shifted and adjusted bounds
  localparam int VW = 35;
  typedef logic signed [VW-1:0] val_t;

  localparam val_t VAL_MAX = val_t'(64'sd2147483647);

  function automatic val_t sx(input logic signed [31:0] v);
    sx = val_t'(v);
  endfunction

  function automatic val_t vmin(input val_t a, input val_t b);
    vmin = (a < b) ? a : b;
  endfunction

  function automatic val_t vmax(input val_t a, input val_t b);
    vmax = (a > b) ? a : b;
  endfunction

endpackage

### src/sorted_interval_set_engine.sv
// sorted interval set engine: table of disjoint, non-adjacent ranges
// depends on sise_pkg
//
// usage: a request (kind, op_low, op_high) is transferred on the input
// channel when in_valid is high and in_stall is low. in_stall stays high
// while a request is being worked on. each request gives one result
// (found, hit_low, hit_high, covered_total, entries_used, status) on the
// output channel, transferred when out_valid is high and out_stall low.
// queries walk the table once, up to the hit; add, remove and trunc
// walk the whole table once, and insert_shift and delete_shift walk it
// twice. the walk reads one range per step from a two-bank table
// memory; edits are written into the other bank and the banks swap on commit.
// a stalled result holds in the output register; the next request may be
// taken meanwhile but its result waits until the register is free.
// reset (rst, synchronous) empties the table and drops any pending result.
module sorted_interval_set_engine #(
  parameter int MAX_RANGES = sise_pkg::MaxRangesDefault,
  parameter int CW = $clog2(MAX_RANGES + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [3:0]          kind,
  input  logic signed [31:0]  op_low,
  input  logic signed [31:0]  op_high,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                found,
  output logic signed [31:0]  hit_low,
  output logic signed [31:0]  hit_high,
  output logic [32:0]         covered_total,
  output logic [CW-1:0]       entries_used,
  output logic [1:0]          status
);
  import sise_pkg::*;

  localparam int AW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_RD   = 7'b0000010,
    S_E0   = 7'b0000100,
    S_E1   = 7'b0001000,
    S_MID  = 7'b0010000,
    S_FIN  = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;

  state_t state;

  logic signed [31:0] lows  [2**(AW+1)];
  logic signed [31:0] highs [2**(AW+1)];
  logic               bank;
  logic signed [31:0] rd_lo, rd_hi;

  logic [3:0]         req_kind;
  logic signed [31:0] req_l, req_h;
  logic [CW-1:0]      idx, nx_n, used;
  logic               pass, done, over;
  logic signed [31:0] pend_lo, pend_hi;
  logic [32:0]        tot, covered;
  logic               found_r;
  logic signed [31:0] hl_r, hh_r;
  logic [1:0]         status_r;

  val_t l, h, span, c_lo, c_hi, hi_c, rl, rh;
  logic c_en, e_take, e_merge, e_new, wr_en;
  logic [AW-1:0] wr_idx;
  logic signed [31:0] wr_lo, wr_hi;
  logic [32:0] pend_span;
  logic [CW-1:0] nx_dec;
  logic bad_range;

  assign l    = sx(req_l);
  assign h    = sx(req_h);
  assign span = h - l + val_t'(1);
  assign rl   = sx(rd_lo);
  assign rh   = sx(rd_hi);

  // candidate range for the shared emit step
  always_comb begin
    c_en = 1'b0;
    c_lo = rl;
    c_hi = rh;
    if (state == S_E0 && !pass) begin
      case (req_kind)
        K_ADD: begin
          c_en = !done && (rl > l);
          c_lo = l;
          c_hi = h;
        end
        K_REMOVE, K_INSERT, K_DELETE: begin
          c_en = 1'b1;
          c_hi = vmin(rh, l - val_t'(1));
        end
        K_TRUNC_LO: begin
          c_en = 1'b1;
          c_lo = vmax(rl, l + val_t'(1));
        end
        K_TRUNC_HI: begin
          c_en = 1'b1;
          c_hi = vmin(rh, l);
        end
        default: c_en = 1'b0;
      endcase
    end else if (state == S_E0) begin
      if (req_kind == K_INSERT) begin
        c_en = rh >= l;
        c_lo = vmax(rl, l) + span;
        c_hi = rh + span;
      end else begin
        c_en = rh > h;
        c_lo = vmax(rl, h + val_t'(1)) - span;
        c_hi = rh - span;
      end
    end else if (state == S_E1) begin
      if (req_kind == K_ADD) begin
        c_en = 1'b1;
      end else if (req_kind == K_REMOVE) begin
        c_en = 1'b1;
        c_lo = vmax(rl, h + val_t'(1));
      end
    end else if (state == S_MID) begin
      c_en = (req_kind == K_INSERT) || (req_kind == K_ADD && !done);
      c_lo = l;
      c_hi = h;
    end
  end

  assign hi_c      = (c_hi > VAL_MAX) ? VAL_MAX : c_hi;
  assign e_take    = c_en && (c_lo <= hi_c);
  assign e_merge   = e_take && (nx_n != '0) && (c_lo <= sx(pend_hi) + val_t'(1));
  assign e_new     = e_take && !e_merge && (nx_n != CW'(MAX_RANGES));
  assign nx_dec    = nx_n - CW'(1);
  // bounds are signed, so extend by the sign bit
  assign pend_span = ({pend_hi[31], pend_hi} - {pend_lo[31], pend_lo}) + 33'd1;

  // flush the pending range when a new one opens, or at the end
  assign wr_en  = (e_new && nx_n != '0) || (state == S_FIN && !over && nx_n != '0);
  assign wr_idx = nx_dec[AW-1:0];
  assign wr_lo  = pend_lo;
  assign wr_hi  = pend_hi;

  assign bad_range = (kind <= K_DELETE || kind == K_CONTAINS) && (op_low > op_high);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      lows[{~bank, wr_idx}]  <= wr_lo;
      highs[{~bank, wr_idx}] <= wr_hi;
    end
    if (state == S_RD) begin
      rd_lo <= lows[{bank, idx[AW-1:0]}];
      rd_hi <= highs[{bank, idx[AW-1:0]}];
    end
  end

  always_ff @(posedge clk) begin
    if (e_merge && hi_c > sx(pend_hi)) pend_hi <= hi_c[31:0];
    if (e_new) begin
      pend_lo <= c_lo[31:0];
      pend_hi <= hi_c[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      bank      <= 1'b0;
      used      <= '0;
      covered   <= '0;
      out_valid <= 1'b0;
      idx       <= '0;
      nx_n      <= '0;
      pass      <= 1'b0;
      done      <= 1'b0;
      over      <= 1'b0;
      tot       <= '0;
      found_r   <= 1'b0;
      status_r  <= ST_OK;
    end else begin
      if (out_valid && !out_stall && state != S_DONE) out_valid <= 1'b0;
      if (e_take && !e_merge && !e_new) over <= 1'b1;
      if (e_new) begin
        nx_n <= nx_n + CW'(1);
        if (nx_n != '0) tot <= tot + pend_span;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            req_kind <= kind;
            req_l    <= op_low;
            req_h    <= op_high;
            idx      <= '0;
            nx_n     <= '0;
            pass     <= 1'b0;
            done     <= 1'b0;
            over     <= 1'b0;
            tot      <= '0;
            found_r  <= 1'b0;
            hl_r     <= '0;
            hh_r     <= '0;
            status_r <= bad_range ? ST_RANGE : ST_OK;
            if (bad_range) begin
              state <= S_DONE;
            end else if (kind == K_CLEAR) begin
              state <= S_FIN;
            end else if (kind > K_CLEAR) begin
              state <= S_DONE;
            end else begin
              state <= S_RD;
            end
          end
        end
        S_RD: begin
          if (idx == used) begin
            case (req_kind)
              K_FIND, K_NEAREST, K_CONTAINS: state <= S_DONE;
              default: state <= pass ? S_FIN : S_MID;
            endcase
          end else begin
            state <= S_E0;
          end
        end
        S_E0: begin
          case (req_kind)
            K_FIND, K_NEAREST, K_CONTAINS: begin
              if (rh >= l) begin
                state <= S_DONE;
                if (req_kind == K_CONTAINS) begin
                  found_r <= rl <= h;
                end else if (req_kind == K_NEAREST || rl <= l) begin
                  found_r <= 1'b1;
                  hl_r    <= rd_lo;
                  hh_r    <= rd_hi;
                end
              end else begin
                idx   <= idx + CW'(1);
                state <= S_RD;
              end
            end
            default: begin
              if (req_kind == K_ADD && c_en) done <= 1'b1;
              state <= S_E1;
            end
          endcase
        end
        S_E1: begin
          idx   <= idx + CW'(1);
          state <= S_RD;
        end
        S_MID: begin
          if (req_kind == K_INSERT || req_kind == K_DELETE) begin
            pass  <= 1'b1;
            idx   <= '0;
            state <= S_RD;
          end else begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (over) begin
            status_r <= ST_FULL;
          end else begin
            bank    <= ~bank;
            used    <= nx_n;
            covered <= (nx_n != '0) ? tot + pend_span : tot;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid     <= 1'b1;
            found         <= found_r;
            hit_low       <= hl_r;
            hit_high      <= hh_r;
            covered_total <= covered;
            entries_used  <= used;
            status        <= status_r;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign in_stall = (state != S_IDLE);

endmodule

### src/sise_checker.sv
// port-level checks for the sorted interval set engine, bound to the top level
// depends on sise_pkg and assert_macros.svh
`include "assert_macros.svh"

module sise_checker #(
  parameter int MAX_RANGES = sise_pkg::MaxRangesDefault,
  parameter int CW = $clog2(MAX_RANGES + 1)
) (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic               found,
  input logic [32:0]        covered_total,
  input logic [CW-1:0]      entries_used,
  input logic [1:0]         status
);
  import sise_pkg::*;

  // a stalled result must hold
  `SISE_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(status) && $stable(covered_total), "stalled result changed")
  // a rejected or dropped request never reports a hit
  `SISE_ASSERT(a_no_hit_on_err, out_valid && status != ST_OK |-> !found, "hit with error status")
  // an empty table covers nothing, and the table never overfills
  `SISE_ASSERT(a_empty_zero, out_valid |-> (entries_used != '0 || covered_total == '0) && entries_used <= CW'(MAX_RANGES), "bad table totals")
  // the block is busy right after taking a request
  `SISE_ASSERT(a_busy_after_take, in_valid && !in_stall |=> in_stall, "not busy after transfer")
  // no result is left over after reset
  `SISE_ASSERT_ALWAYS(a_rst_clear, rst |=> !out_valid, "result valid after reset")

endmodule

bind sorted_interval_set_engine sise_checker #(
  .MAX_RANGES(MAX_RANGES),
  .CW(CW)
) u_sise_checker (
  .clk(clk),
  .rst(rst),
  .in_valid(in_valid),
  .in_stall(in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .found(found),
  .covered_total(covered_total),
  .entries_used(entries_used),
  .status(status)
);

### dv/tb_top.sv
// self-checking testbench for the sorted interval set engine
// depends on sise_pkg and sorted_interval_set_engine; a scoreboard class
// predicts each result from its own copy of the range table
module tb_top;
  import sise_pkg::*;

  localparam int MAXR = MaxRangesDefault;
  localparam int CW = $clog2(MAXR + 1);
  localparam longint TOP = 64'sd2147483647;
  localparam longint BOT = -64'sd2147483648;
  localparam int LIMIT = 2000000;

  typedef struct {
    logic               found;
    logic signed [31:0] hit_low;
    logic signed [31:0] hit_high;
    logic [32:0]        covered;
    logic [CW-1:0]      used;
    logic [1:0]         status;
  } interval_result_t;

  class interval_scoreboard;
    longint rlo[MAXR], rhi[MAXR];
    int used;
    longint covered;
    longint nlo[MAXR], nhi[MAXR];
    int nn;
    bit over;
    interval_result_t pending[$];
    int errors;

    function new();
      used = 0;
      covered = 0;
      errors = 0;
    endfunction

    // append to the next table, merging with the last range where they touch
    function void put(longint a, longint b);
      if (b > TOP) b = TOP;
      if (a > b) return;
      if (nn > 0 && a <= nhi[nn-1] + 1) begin
        if (b > nhi[nn-1]) nhi[nn-1] = b;
        return;
      end
      if (nn >= MAXR) begin
        over = 1;
        return;
      end
      nlo[nn] = a;
      nhi[nn] = b;
      nn++;
    endfunction

    function longint mn(longint a, longint b);
      return a < b ? a : b;
    endfunction

    function longint mx(longint a, longint b);
      return a > b ? a : b;
    endfunction

    function void note(logic [3:0] k, logic signed [31:0] ol, logic signed [31:0] oh);
      longint l, h, span;
      interval_result_t e;
      bit edit, done;
      int i;
      l = ol;
      h = oh;
      span = h - l + 1;
      e = '{default: '0};
      edit = 0;
      done = 0;
      nn = 0;
      over = 0;
      if ((k <= K_DELETE || k == K_CONTAINS) && l > h) begin
        e.status = ST_RANGE;
      end else begin
        case (k)
          K_ADD: begin
            for (i = 0; i < used; i++) begin
              if (!done && rlo[i] > l) begin
                put(l, h);
                done = 1;
              end
              put(rlo[i], rhi[i]);
            end
            if (!done) put(l, h);
            edit = 1;
          end
          K_REMOVE: begin
            for (i = 0; i < used; i++) begin
              put(rlo[i], mn(rhi[i], l - 1));
              put(mx(rlo[i], h + 1), rhi[i]);
            end
            edit = 1;
          end
          K_INSERT: begin
            for (i = 0; i < used; i++) put(rlo[i], mn(rhi[i], l - 1));
            put(l, h);
            for (i = 0; i < used; i++)
              if (rhi[i] >= l) put(mx(rlo[i], l) + span, rhi[i] + span);
            edit = 1;
          end
          K_DELETE: begin
            for (i = 0; i < used; i++) put(rlo[i], mn(rhi[i], l - 1));
            for (i = 0; i < used; i++)
              if (rhi[i] > h) put(mx(rlo[i], h + 1) - span, rhi[i] - span);
            edit = 1;
          end
          K_FIND, K_NEAREST, K_CONTAINS: begin
            i = 0;
            while (i < used && rhi[i] < l) i++;
            if (k == K_CONTAINS) begin
              if (i < used && rlo[i] <= h) e.found = 1;
            end else if (i < used && (k == K_NEAREST || rlo[i] <= l)) begin
              e.found = 1;
              e.hit_low = rlo[i][31:0];
              e.hit_high = rhi[i][31:0];
            end
          end
          K_TRUNC_LO: begin
            for (i = 0; i < used; i++) put(mx(rlo[i], l + 1), rhi[i]);
            edit = 1;
          end
          K_TRUNC_HI: begin
            for (i = 0; i < used; i++) put(rlo[i], mn(rhi[i], l));
            edit = 1;
          end
          K_CLEAR: edit = 1;
          default: ;
        endcase
        if (edit) begin
          if (over) begin
            e.status = ST_FULL;
          end else begin
            covered = 0;
            for (i = 0; i < nn; i++) begin
              rlo[i] = nlo[i];
              rhi[i] = nhi[i];
              covered += nhi[i] - nlo[i] + 1;
            end
            used = nn;
          end
        end
      end
      e.covered = covered[32:0];
      e.used = CW'(used);
      pending.push_back(e);
    endfunction

    function void check(interval_result_t got);
      interval_result_t w;
      if (pending.size() == 0) begin
        $error("result transfer with nothing expected");
        errors++;
        return;
      end
      w = pending.pop_front();
      if (got.found !== w.found) begin
        $error("found: expected %0d, got %0d", w.found, got.found);
        errors++;
      end
      if (got.hit_low !== w.hit_low) begin
        $error("hit_low: expected %0d, got %0d", w.hit_low, got.hit_low);
        errors++;
      end
      if (got.hit_high !== w.hit_high) begin
        $error("hit_high: expected %0d, got %0d", w.hit_high, got.hit_high);
        errors++;
      end
      if (got.covered !== w.covered) begin
        $error("covered_total: expected %0d, got %0d", w.covered, got.covered);
        errors++;
      end
      if (got.used !== w.used) begin
        $error("entries_used: expected %0d, got %0d", w.used, got.used);
        errors++;
      end
      if (got.status !== w.status) begin
        $error("status: expected %0d, got %0d", w.status, got.status);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  logic [3:0] kind = K_CLEAR;
  logic signed [31:0] op_low = 0;
  logic signed [31:0] op_high = 0;
  logic out_valid;
  logic out_stall = 0;
  logic found;
  logic signed [31:0] hit_low, hit_high;
  logic [32:0] covered_total;
  logic [CW-1:0] entries_used;
  logic [1:0] status;

  sorted_interval_set_engine dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .kind(kind), .op_low(op_low), .op_high(op_high),
    .out_valid(out_valid), .out_stall(out_stall),
    .found(found), .hit_low(hit_low), .hit_high(hit_high),
    .covered_total(covered_total), .entries_used(entries_used), .status(status)
  );

  interval_scoreboard sb = new();
  int send_idle = 0;
  int recv_idle = 0;
  int hold_left = 0;
  bit hold_req = 0;
  int cycles = 0;

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // receiver side: random stalls plus one long hold-off
  always @(posedge clk) begin
    if (hold_req && hold_left == 0) begin
      hold_left <= 3000;
      hold_req <= 0;
      out_stall <= 1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle);
    end
  end

  // outputs are stable at the falling edge; a transfer follows at the next rise
  always @(negedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check('{found, hit_low, hit_high, covered_total, entries_used, status});
  end

  // called just after a rising edge; returns at the edge of the transfer
  task automatic send(logic [3:0] k, longint l, longint h);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    kind <= k;
    op_low <= l[31:0];
    op_high <= h[31:0];
    forever begin
      @(negedge clk);
      if (!in_stall) break;
      @(posedge clk);
    end
    @(posedge clk);
    sb.note(k, l[31:0], h[31:0]);
  endtask

  function automatic longint pick_val();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return longint'($urandom_range(0, 400)) - 200;
    if (r < 85) return TOP - longint'($urandom_range(0, 300));
    if (r < 95) return BOT + longint'($urandom_range(0, 300));
    return longint'(int'($urandom()));
  endfunction

  task automatic random_item();
    int r;
    longint l, h;
    logic [3:0] k;
    r = $urandom_range(0, 99);
    if (r < 30) k = K_ADD;
    else if (r < 42) k = K_REMOVE;
    else if (r < 50) k = K_INSERT;
    else if (r < 58) k = K_DELETE;
    else if (r < 66) k = K_FIND;
    else if (r < 74) k = K_NEAREST;
    else if (r < 82) k = K_CONTAINS;
    else if (r < 86) k = K_TRUNC_LO;
    else if (r < 90) k = K_TRUNC_HI;
    else if (r < 91) k = K_CLEAR;
    else if (r < 93) k = 4'(K_CLEAR + 1 + $urandom_range(0, 5));
    else k = 4'($urandom_range(0, 15));
    if (r >= 93) begin
      // noise: raw fields, often low above high
      l = longint'(int'($urandom()));
      h = longint'(int'($urandom()));
    end else begin
      l = pick_val();
      h = l + $urandom_range(0, ($urandom_range(0, 9) == 0) ? 200 : 6);
      if (h > TOP) h = TOP;
    end
    send(k, l, h);
  endtask

  initial begin
    int i, ph;
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed part
    send(K_ADD, BOT, BOT);
    send(K_ADD, TOP, TOP);
    send(K_FIND, BOT, 0);
    send(K_ADD, BOT, TOP);
    send(K_NEAREST, 0, 0);
    send(K_REMOVE, 0, 0);
    send(K_CONTAINS, 0, 0);
    send(K_REMOVE, 5, 4);
    send(K_CONTAINS, 9, 8);
    send(K_INSERT, 5, 9);
    send(K_DELETE, -3, 3);
    send(K_CLEAR, 0, 0);
    send(K_ADD, 0, 2);
    send(K_ADD, 6, 8);
    send(K_ADD, 4, 4);
    send(K_DELETE, 3, 5);
    send(K_ADD, 10, 20);
    send(K_TRUNC_LO, 12, 0);
    send(K_TRUNC_HI, 18, 0);
    send(K_FIND, 100, 0);
    send(K_NEAREST, 100, 0);
    send(K_INSERT, TOP - 1, TOP);
    send(4'hF, -1, -1);
    send(K_CLEAR, 0, 0);

    for (ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 8 : (ph == 1) ? 61 : 0;
      recv_idle = (ph == 0) ? 61 : (ph == 1) ? 8 : 0;
      if (ph == 2) hold_req = 1;
      // fill the table past its depth
      for (i = 0; i < MAXR + 3; i++) send(K_ADD, 4 * i - 600, 4 * i - 599);
      send(K_REMOVE, -590, -590);
      for (i = 0; i < 150; i++) random_item();
      send(K_CLEAR, 0, 0);
    end

    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("tb_top: clean");
    else
      $display("tb_top: errors");
    $finish;
  end
endmodule
